FILE: rtl/core/pidl_pkg.sv
package pidl_pkg;

  typedef enum logic [2:0] {
    OP_ADD_FRONT    = 3'd0,
    OP_ADD_END      = 3'd1,
    OP_INSERT_AT    = 3'd2,
    OP_DELETE_FRONT = 3'd3,
    OP_DELETE_AT    = 3'd4,
    OP_CLEAR        = 3'd5,
    OP_READ_OUT     = 3'd6
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // What one cell loads at the next clock edge.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_LEFT,
    CELL_RIGHT,
    CELL_HEAD
  } cell_sel_t;

  localparam int unsigned IO_WIDTH    = 32;
  localparam int unsigned POS_WIDTH   = 5;
  localparam int unsigned COUNT_WIDTH = 5;

endpackage

FILE: rtl/core/positional_insert_delete_list.sv
// Bounded ordered list of signed values, held in a row of CAPACITY cells where
// cell 0 is the front of the list. A command transaction is accepted on a
// clock edge with start high and busy low. Add front, add end, insert at,
// delete front, delete at and clear finish in the accepting edge: the affected
// cells shift toward or away from the front at once, and the single result
// shows on the result ports in the next cycle with last_result high, so these
// commands can be issued back to back, one per cycle. Read-out of a list
// holding N elements keeps busy high until the last one is copied out: each
// cycle the front cell is copied out and the first N cells rotate by one
// toward the front, which brings the list back to its original order after
// the final element. The elements appear in list order, each registered at
// its rotation step, the last one with last_result high; an empty list gives
// one result with the empty status instead. Every result is valid for exactly
// one cycle while result_valid is high and cannot be held off by the receiver.
// A rejected command (bad position, empty or full list) leaves the list
// unchanged and reports its status. Opcode 7 is ignored and gives no result.
module positional_insert_delete_list #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          opcode,
  input  logic [pidl_pkg::POS_WIDTH-1:0]      position,
  input  logic signed [pidl_pkg::IO_WIDTH-1:0] value,
  output logic                                result_valid,
  output logic [1:0]                          status,
  output logic signed [pidl_pkg::IO_WIDTH-1:0] element,
  output logic [pidl_pkg::COUNT_WIDTH-1:0]    element_count,
  output logic                                last_result
);
  import pidl_pkg::*;

  // The count must hold CAPACITY itself; compares use a width that also
  // covers the position field.
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CW > POS_WIDTH) ? CW : POS_WIDTH;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [CW-1:0]   rd_left;

  logic [VALUE_WIDTH-1:0] cell_q [CAPACITY];
  cell_sel_t              cell_sel [CAPACITY];
  logic [VALUE_WIDTH-1:0] store_val;
  logic [IO_WIDTH-1:0]    head_out;

  logic             accept;
  logic [CMP_W-1:0] cnt_e;
  logic [CMP_W-1:0] pos_e;
  logic [CMP_W-1:0] ins_pos;
  logic [CMP_W-1:0] del_pos;
  logic             do_ins;
  logic             do_del;
  logic             do_emit;
  logic             go_read;
  status_t          ed_status;
  logic [CW-1:0]    count_next;
  logic [CMP_W-1:0] count_next_e;

  assign busy   = (state == S_READ);
  assign accept = start && !busy;
  assign cnt_e  = CMP_W'(count);
  assign pos_e  = CMP_W'(position);
  assign count_next_e = CMP_W'(count_next);

  // Width conversion of a stored value on the way in and on the way out.
  generate
    if (VALUE_WIDTH > IO_WIDTH) begin : g_wide
      assign store_val = {{(VALUE_WIDTH - IO_WIDTH){value[IO_WIDTH-1]}}, value};
      assign head_out  = cell_q[0][IO_WIDTH-1:0];
    end else if (VALUE_WIDTH == IO_WIDTH) begin : g_same
      assign store_val = value;
      assign head_out  = cell_q[0];
    end else begin : g_narrow
      assign store_val = value[VALUE_WIDTH-1:0];
      assign head_out  = {{(IO_WIDTH - VALUE_WIDTH){cell_q[0][VALUE_WIDTH-1]}}, cell_q[0]};
    end
  endgenerate

  // Decode of one command: whether it edits the list, its status, and the
  // count it leaves behind.
  always_comb begin
    ins_pos    = cnt_e;
    del_pos    = '0;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    do_emit    = 1'b1;
    go_read    = 1'b0;
    ed_status  = ST_OK;
    count_next = count;
    case (opcode_t'(opcode))
      OP_ADD_FRONT: begin
        ins_pos = '0;
        do_ins  = 1'b1;
      end
      OP_ADD_END: begin
        ins_pos = cnt_e;
        do_ins  = 1'b1;
      end
      OP_INSERT_AT: begin
        ins_pos = pos_e;
        do_ins  = 1'b1;
      end
      OP_DELETE_FRONT: begin
        if (count == '0) begin
          ed_status = ST_EMPTY;
        end else begin
          do_del  = 1'b1;
          del_pos = '0;
        end
      end
      OP_DELETE_AT: begin
        if (pos_e >= cnt_e) begin
          ed_status = ST_INVALID;
        end else begin
          do_del  = 1'b1;
          del_pos = pos_e;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      OP_READ_OUT: begin
        if (count == '0) begin
          ed_status = ST_EMPTY;
        end else begin
          do_emit = 1'b0;
          go_read = 1'b1;
        end
      end
      default: begin
        do_emit = 1'b0;
      end
    endcase
    // The position check on an insert comes before the full check.
    if (do_ins) begin
      if (ins_pos > cnt_e) begin
        ed_status = ST_INVALID;
        do_ins    = 1'b0;
      end else if (count == CW'(CAPACITY)) begin
        ed_status = ST_FULL;
        do_ins    = 1'b0;
      end else begin
        count_next = count + 1'b1;
      end
    end
    if (do_del) begin
      count_next = count - 1'b1;
    end
  end

  // The row of cells. Each cell's move is set by how its index compares to
  // the edit position and to the count.
  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [CMP_W-1:0] IDX  = CMP_W'(i);
      localparam logic [CMP_W-1:0] IDX1 = CMP_W'(i + 1);

      logic [VALUE_WIDTH-1:0] left_in;
      logic [VALUE_WIDTH-1:0] right_in;

      if (i == 0) begin : g_first
        assign left_in = store_val;
      end else begin : g_mid_l
        assign left_in = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_in = cell_q[i];
      end else begin : g_mid_r
        assign right_in = cell_q[i+1];
      end

      always_comb begin
        cell_sel[i] = CELL_HOLD;
        if (state == S_READ) begin
          // Rotate the occupied cells one step toward the front.
          if (IDX1 < cnt_e) begin
            cell_sel[i] = CELL_RIGHT;
          end else if (IDX1 == cnt_e) begin
            cell_sel[i] = CELL_HEAD;
          end
        end else if (accept && do_ins) begin
          if (IDX == ins_pos) begin
            cell_sel[i] = CELL_LOAD;
          end else if (IDX > ins_pos && IDX <= cnt_e) begin
            cell_sel[i] = CELL_LEFT;
          end
        end else if (accept && do_del) begin
          if (IDX >= del_pos && IDX1 < cnt_e) begin
            cell_sel[i] = CELL_RIGHT;
          end
        end
      end

      pidl_cell #(
        .VALUE_WIDTH(VALUE_WIDTH)
      ) u_cell (
        .clk      (clk),
        .sel      (cell_sel[i]),
        .load_val (store_val),
        .left     (left_in),
        .right    (right_in),
        .head     (cell_q[0]),
        .q        (cell_q[i])
      );
    end
  endgenerate

  // Command sequencing and the registered result ports.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      rd_left      <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            count <= count_next;
            if (do_emit) begin
              result_valid  <= 1'b1;
              status        <= ed_status;
              element       <= '0;
              element_count <= count_next_e[COUNT_WIDTH-1:0];
              last_result   <= 1'b1;
            end
            if (go_read) begin
              state   <= S_READ;
              rd_left <= count;
            end
          end
        end
        S_READ: begin
          result_valid  <= 1'b1;
          status        <= ST_OK;
          element       <= head_out;
          element_count <= cnt_e[COUNT_WIDTH-1:0];
          last_result   <= (rd_left == CW'(1));
          rd_left       <= rd_left - 1'b1;
          if (rd_left == CW'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/pidl_cell.sv
module pidl_cell #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  pidl_pkg::cell_sel_t    sel,
  input  logic [VALUE_WIDTH-1:0] load_val,
  input  logic [VALUE_WIDTH-1:0] left,
  input  logic [VALUE_WIDTH-1:0] right,
  input  logic [VALUE_WIDTH-1:0] head,
  output logic [VALUE_WIDTH-1:0] q
);
  import pidl_pkg::*;

  logic [VALUE_WIDTH-1:0] q_next;

  // The cell takes its new value from the command, a neighbor, or the head cell.
  always_comb begin
    case (sel)
      CELL_LOAD:  q_next = load_val;
      CELL_LEFT:  q_next = left;
      CELL_RIGHT: q_next = right;
      CELL_HEAD:  q_next = head;
      default:    q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule
